// ----- sv/rv32ie_pkg.sv -----
// Shared constants and payload types of the RV32I instruction executor.
`default_nettype none
package rv32ie_pkg;
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int ROWS = MEM_BYTES / 4;
	localparam int ROW_W = ADDR_W - 2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ECALL = 2'd1;
	localparam logic [1:0] STATUS_EBREAK = 2'd2;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd3;

	localparam logic [1:0] CFG_START_PC = 2'd0;
	localparam logic [1:0] CFG_STACK_TOP = 2'd1;
	localparam logic [1:0] CFG_DATA_BASE = 2'd2;

	typedef struct packed {
		logic kind;
		logic [13:0] preload_address;
		logic [31:0] preload_word;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] pc_after;
		logic reg_written;
		logic [4:0] dest_index;
		logic [31:0] dest_value;
	} out_t;
endpackage
`default_nettype wire

// ----- sv/rv32ie_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module rv32ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- sv/rv32i_instruction_executor.sv -----
// Top level of the RV32I instruction executor: control, decode, ALU and memories.
`default_nettype none
// An execute item steps through fetch read, register read, execute and result
// transfer, a load adds a data memory read, and a preload writes its word and
// then transfers; the single port of the byte memory lanes and the register file
// set these steps. The byte memory is four byte-lane RAMs; after reset a clearing
// pass over all MEM_BYTES/4 rows zeroes it, and no item is taken until it ends.
// Configuration writes take effect at once and may be given at any idle time.
module rv32i_instruction_executor
	import rv32ie_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_DEC = 3'd3;
	localparam logic [2:0] ST_EX = 3'd4;
	localparam logic [2:0] ST_MEM = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [6:0] OPC_OP = 7'b0110011;
	localparam logic [6:0] OPC_OPIMM = 7'b0010011;
	localparam logic [6:0] OPC_LOAD = 7'b0000011;
	localparam logic [6:0] OPC_STORE = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL = 7'b1101111;
	localparam logic [6:0] OPC_JALR = 7'b1100111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [6:0] OPC_LUI = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC = 7'b0010111;
	localparam logic [6:0] OPC_FENCE = 7'b0001111;
	localparam logic [6:0] F7_ALT = 7'b0100000;
	localparam logic [31:0] INS_ECALL = 32'h00000073;
	localparam logic [31:0] INS_EBREAK = 32'h00100073;

	logic [2:0] state_q;
	logic clr_q;
	logic [ROW_W-1:0] clr_row_q;
	logic [31:0] pc_q, stack_top_q, data_base_q;
	logic [31:0] rf_v_q;
	in_t in_q;
	logic [31:0] ins_q;
	logic [1:0] off_q;
	out_t res_q;
	out_t out_q;
	logic out_valid_q;

	logic [3:0] lane_we;
	logic [ROW_W-1:0] lane_row [4];
	logic [7:0] lane_wd [4];
	logic [7:0] lane_rd [4];
	logic [31:0] lane_w;
	logic [31:0] lane_wdata;
	logic [31:0] mem_ba;
	logic [31:0] rot_rd;

	logic rf_we;
	logic [4:0] rfa_addr, rfb_addr;
	logic [31:0] rf_wdata, rfa_rd, rfb_rd;

	logic [31:0] ins;
	logic [6:0] opc, f7;
	logic [2:0] f3;
	logic [4:0] rd, rs1, rs2;
	logic [31:0] a, b, i_imm, s_imm, b_imm, j_imm, u_imm, alu_b, alu_res;
	logic alu_ok, imm_form, f7zero, f7alt, taken, lts, ltu;
	logic [1:0] ex_status;
	logic [31:0] ex_next, ex_res, ex_addr;
	logic ex_wr, ex_load, ex_store;
	logic [31:0] ld_val;

	function automatic logic [31:0] init_val(input logic [4:0] idx, input logic [31:0] st,
			input logic [31:0] db);
		logic [31:0] v;
		v = 32'd0;
		if (idx == 5'd2) v = st;
		if (idx == 5'd3) v = db;
		return v;
	endfunction

	assign in_ready = (state_q == ST_IDLE) && !clr_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign ins = ins_q;
	assign opc = ins[6:0];
	assign rd = ins[11:7];
	assign f3 = ins[14:12];
	assign rs1 = ins[19:15];
	assign rs2 = ins[24:20];
	assign f7 = ins[31:25];
	assign i_imm = {{20{ins[31]}}, ins[31:20]};
	assign s_imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign b_imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign j_imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign u_imm = {ins[31:12], 12'd0};
	assign a = rf_v_q[rs1] ? rfa_rd : init_val(rs1, stack_top_q, data_base_q);
	assign b = rf_v_q[rs2] ? rfb_rd : init_val(rs2, stack_top_q, data_base_q);

	assign imm_form = (opc == OPC_OPIMM);
	assign alu_b = imm_form ? i_imm : b;
	assign f7zero = (f7 == 7'd0);
	assign f7alt = (f7 == F7_ALT);
	assign lts = $signed(a) < $signed(alu_b);
	assign ltu = a < alu_b;

	always_comb begin
		alu_ok = imm_form || f7zero;
		alu_res = 32'd0;
		unique case (f3)
			3'd0: begin
				alu_ok = imm_form || f7zero || f7alt;
				alu_res = (!imm_form && f7alt) ? a - alu_b : a + alu_b;
			end
			3'd1: begin
				alu_ok = f7zero;
				alu_res = a << alu_b[4:0];
			end
			3'd2: alu_res = {31'd0, lts};
			3'd3: alu_res = {31'd0, ltu};
			3'd4: alu_res = a ^ alu_b;
			3'd5: begin
				alu_ok = f7zero || f7alt;
				alu_res = f7alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
			end
			3'd6: alu_res = a | alu_b;
			default: alu_res = a & alu_b;
		endcase
	end

	always_comb begin
		taken = 1'b0;
		unique case (f3)
			3'd0: taken = (a == b);
			3'd1: taken = (a != b);
			3'd4: taken = $signed(a) < $signed(b);
			3'd5: taken = !($signed(a) < $signed(b));
			3'd6: taken = a < b;
			3'd7: taken = a >= b;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		ex_status = STATUS_OK;
		ex_next = pc_q + 32'd4;
		ex_res = 32'd0;
		ex_wr = 1'b0;
		ex_load = 1'b0;
		ex_store = 1'b0;
		ex_addr = a + i_imm;
		unique case (opc)
			OPC_OP, OPC_OPIMM: begin
				ex_res = alu_res;
				ex_wr = alu_ok;
				if (!alu_ok) ex_status = STATUS_ILLEGAL;
			end
			OPC_LUI: begin
				ex_res = u_imm;
				ex_wr = 1'b1;
			end
			OPC_AUIPC: begin
				ex_res = pc_q + u_imm;
				ex_wr = 1'b1;
			end
			OPC_JAL: begin
				ex_res = pc_q + 32'd4;
				ex_wr = 1'b1;
				ex_next = pc_q + j_imm;
			end
			OPC_JALR: begin
				if (f3 != 3'd0) begin
					ex_status = STATUS_ILLEGAL;
				end else begin
					ex_res = pc_q + 32'd4;
					ex_wr = 1'b1;
					ex_next = (a + i_imm) & ~32'd1;
				end
			end
			OPC_BRANCH: begin
				if (f3 == 3'd2 || f3 == 3'd3) ex_status = STATUS_ILLEGAL;
				else if (taken) ex_next = pc_q + b_imm;
			end
			OPC_LOAD: begin
				if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
					ex_status = STATUS_ILLEGAL;
				end else begin
					ex_load = 1'b1;
					ex_wr = 1'b1;
				end
			end
			OPC_STORE: begin
				ex_addr = a + s_imm;
				if (f3 > 3'd2) ex_status = STATUS_ILLEGAL;
				else ex_store = 1'b1;
			end
			OPC_FENCE: begin
				if (f3 > 3'd1) ex_status = STATUS_ILLEGAL;
			end
			OPC_SYSTEM: begin
				if (ins == INS_ECALL) ex_status = STATUS_ECALL;
				else if (ins == INS_EBREAK) ex_status = STATUS_EBREAK;
				else ex_status = STATUS_ILLEGAL;
			end
			default: ex_status = STATUS_ILLEGAL;
		endcase
		if (ex_status == STATUS_ILLEGAL) begin
			ex_next = pc_q;
			ex_wr = 1'b0;
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			lane_w[8*l +: 8] = lane_rd[l];
		end
		rot_rd = 32'({lane_w, lane_w} >> {off_q, 3'b000});
		unique case (f3)
			3'd0: ld_val = {{24{rot_rd[7]}}, rot_rd[7:0]};
			3'd1: ld_val = {{16{rot_rd[15]}}, rot_rd[15:0]};
			3'd4: ld_val = {24'd0, rot_rd[7:0]};
			3'd5: ld_val = {16'd0, rot_rd[15:0]};
			default: ld_val = rot_rd;
		endcase
	end

	always_comb begin
		logic [1:0] k;
		mem_ba = pc_q;
		lane_wdata = 32'd0;
		lane_we = 4'd0;
		if (state_q == ST_PRE) begin
			mem_ba = {16'd0, in_q.preload_address, 2'b00};
			lane_wdata = in_q.preload_word;
			lane_we = 4'hF;
		end else if (state_q == ST_EX) begin
			mem_ba = ex_addr;
			lane_wdata = 32'({b, b} << {ex_addr[1:0], 3'b000} >> 32);
		end
		for (int l = 0; l < 4; l++) begin
			k = 2'(l) - mem_ba[1:0];
			lane_row[l] = mem_ba[ADDR_W-1:2] + ROW_W'(2'(l) < mem_ba[1:0]);
			lane_wd[l] = lane_wdata[8*l +: 8];
			if (state_q == ST_EX && ex_store && ({1'b0, k} < (3'd1 << f3[1:0])))
				lane_we[l] = 1'b1;
			if (clr_q) begin
				lane_row[l] = clr_row_q;
				lane_wd[l] = 8'd0;
				lane_we[l] = 1'b1;
			end
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		rv32ie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
			.clk(clk),
			.we(lane_we[l]),
			.addr(lane_row[l]),
			.wdata(lane_wd[l]),
			.rdata(lane_rd[l])
		);
	end

	always_comb begin
		rf_we = 1'b0;
		rf_wdata = ex_res;
		rfa_addr = rot_rd[19:15];
		rfb_addr = rot_rd[24:20];
		if (state_q == ST_EX) begin
			rfa_addr = rd;
			rfb_addr = rd;
			rf_we = ex_wr && !ex_load && (rd != 5'd0);
		end else if (state_q == ST_MEM) begin
			rfa_addr = rd;
			rfb_addr = rd;
			rf_wdata = ld_val;
			rf_we = (rd != 5'd0);
		end
	end

	rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .addr(rfa_addr), .wdata(rf_wdata), .rdata(rfa_rd)
	);
	rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .addr(rfb_addr), .wdata(rf_wdata), .rdata(rfb_rd)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_q <= in_data;
		if (state_q == ST_DEC) ins_q <= rot_rd;
		if (state_q == ST_FETCH) off_q <= pc_q[1:0];
		if (state_q == ST_EX) off_q <= ex_addr[1:0];
		if (state_q == ST_PRE) begin
			res_q <= '{STATUS_OK, pc_q, 1'b0, 5'd0, 32'd0};
		end else if (state_q == ST_EX) begin
			if (ex_wr && rd != 5'd0) res_q <= '{ex_status, ex_next, 1'b1, rd, ex_res};
			else res_q <= '{ex_status, ex_next, 1'b0, 5'd0, 32'd0};
		end else if (state_q == ST_MEM) begin
			if (rd != 5'd0) res_q.dest_value <= ld_val;
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_row_q <= '0;
			pc_q <= 32'd0;
			stack_top_q <= 32'd0;
			data_base_q <= 32'd0;
			rf_v_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_row_q == ROW_W'(ROWS - 1)) clr_q <= 1'b0;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (rf_we) rf_v_q[rd] <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) state_q <= in_data.kind ? ST_PRE : ST_FETCH;
				end
				ST_PRE: state_q <= ST_DONE;
				ST_FETCH: state_q <= ST_DEC;
				ST_DEC: state_q <= ST_EX;
				ST_EX: begin
					pc_q <= ex_next;
					state_q <= ex_load ? ST_MEM : ST_DONE;
				end
				ST_MEM: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_PC: pc_q <= cfg_data;
					CFG_STACK_TOP: begin
						stack_top_q <= cfg_data;
						rf_v_q[2] <= 1'b0;
					end
					CFG_DATA_BASE: begin
						data_base_q <= cfg_data;
						rf_v_q[3] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire
